>>> design/gce_pkg.sv
// Shared types, codes and helpers for the graph-cut pixel energy block.
package gce_pkg;

  // Input item kinds
  localparam logic [1:0] MODE_PIXEL = 2'd0;
  localparam logic [1:0] MODE_FORE  = 2'd1;
  localparam logic [1:0] MODE_BACK  = 2'd2;
  localparam logic [1:0] MODE_SKIP  = 2'd3;

  // Seed labels
  localparam logic [1:0] SEED_NONE  = 2'd0;
  localparam logic [1:0] SEED_FORE  = 2'd1;
  localparam logic [1:0] SEED_BACK  = 2'd2;
  localparam logic [1:0] SEED_SPARE = 2'd3;

  // Register indexes on the APB port
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SCALE  = 2'd2;
  localparam logic [1:0] REG_COLOR  = 2'd3;

  // Operand slots for the shared sqrt and divide units
  localparam logic [1:0] OP_FORE = 2'd0;
  localparam logic [1:0] OP_BACK = 2'd1;
  localparam logic [1:0] OP_LEFT = 2'd2;
  localparam logic [1:0] OP_UP   = 2'd3;

  localparam logic [23:0] INF_COST = 24'hFFFFFF;

  typedef enum logic [3:0] {
    S_IDLE, S_DIST, S_SCAN, S_SQ_GO, S_SQ_WAIT, S_MUL1, S_MUL2, S_MUL3,
    S_DV_GO, S_DV_WAIT, S_DONE
  } gce_state_t;

  // Squared RGB distance of two packed pixels
  function automatic logic [17:0] sq_dist(input logic [23:0] a, input logic [23:0] b);
    logic [7:0]  dr, dg, db;
    logic [15:0] sr, sg, sb;
    dr = (a[23:16] >= b[23:16]) ? a[23:16] - b[23:16] : b[23:16] - a[23:16];
    dg = (a[15:8] >= b[15:8]) ? a[15:8] - b[15:8] : b[15:8] - a[15:8];
    db = (a[7:0] >= b[7:0]) ? a[7:0] - b[7:0] : b[7:0] - a[7:0];
    sr = 16'(dr) * 16'(dr);
    sg = 16'(dg) * 16'(dg);
    sb = 16'(db) * 16'(db);
    return 18'(sr) + 18'(sg) + 18'(sb);
  endfunction

endpackage

>>> design/gce_sqrt.sv
// Iterative square root of value * 65536, two radicand bits per cycle.
module gce_sqrt import gce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [17:0] value,
  output logic        done,
  output logic [16:0] root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [33:0] src;
  logic [18:0] rem;
  logic [20:0] rem_sh;
  logic [20:0] trial;
  logic        fits;

  assign rem_sh = {rem, src[33:32]};
  assign trial  = 21'({root, 2'b01});
  assign fits   = rem_sh >= trial;

  // Control: run seventeen steps after start
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 5'd16);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd16) busy <= 1'b0;
      end
    end
  end

  // Datapath: restoring root step
  always_ff @(posedge clk) begin
    if (start) begin
      src  <= {value, 16'b0};
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      src  <= {src[31:0], 2'b00};
      rem  <= fits ? 19'(rem_sh - trial) : rem_sh[18:0];
      root <= {root[15:0], fits};
    end
  end

endmodule

>>> design/gce_div.sv
// Iterative restoring divider, 24 quotient bits, one bit per cycle.
module gce_div import gce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [43:0] num,
  input  logic [19:0] den,
  output logic        done,
  output logic [23:0] quot
);

  logic        busy;
  logic [4:0]  cnt;
  logic [19:0] dvs;
  logic [19:0] rem;
  logic [23:0] low;
  logic [20:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem, low[23]};
  assign fits   = rem_sh >= 21'(dvs);

  // Control: run twenty-four steps after start
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 5'd23);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd23) busy <= 1'b0;
      end
    end
  end

  // Datapath: the quotient fits 24 bits, so start from the top numerator bits
  always_ff @(posedge clk) begin
    if (start) begin
      dvs  <= den;
      rem  <= num[43:24];
      low  <= num[23:0];
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? 20'(rem_sh - 21'(dvs)) : rem_sh[19:0];
      low  <= {low[22:0], 1'b0};
      quot <= {quot[22:0], fits};
    end
  end

endmodule

>>> design/graph_cut_pixel_energy.sv
// Top level: sequencer, centre tables, line store and result register.
//
//  channel | dir | transfer moves
//  s_*     | in  | pixel or centre load item
//  m_*     | out | energy terms of one pixel, tlast on the image's last pixel
//  APB     | in  | image_width, image_height, scale_factor, color_factor
//
// A pixel goes through the scan, one centre pair per cycle, then four roots on the
// shared 17-step sqrt unit, the multiply steps, four quotients on the shared 24-step
// divider, then the result. A load item or an ignored item leaves the sequencer idle
// and ready for the next item.
// Reset is synchronous and clears control state; tables start undefined.
// A pending result stalls only the final step; the next item is taken after it.
module graph_cut_pixel_energy import gce_pkg::*; #(
  parameter int NUM_CENTERS = 8,
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 4096
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // center_slot[5:0], red[13:6], green[21:14], blue[29:22], seed_label[31:30]
  input  logic [31:0]  s_tdata,
  // mode[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // node_index[21:0], cost_fore[45:22], cost_back[69:46], weight_left[93:70],
  // left_valid[94], weight_up[118:95], up_valid[119]
  output logic [119:0] m_tdata,
  output logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int CW = (NUM_CENTERS > 1) ? $clog2(NUM_CENTERS) : 1;
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  gce_state_t state, state_next;

  logic [10:0] image_width;
  logic [12:0] image_height;
  logic [15:0] scale_factor;
  logic [8:0]  color_factor;

  // Configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd1024;
      image_height <= 13'd1024;
      scale_factor <= 16'd100;
      color_factor <= 9'd128;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_WIDTH:  image_width  <= pwdata[10:0];
        REG_HEIGHT: image_height <= pwdata[12:0];
        REG_SCALE:  scale_factor <= pwdata[15:0];
        REG_COLOR:  color_factor <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      REG_SCALE:  prdata = 32'(scale_factor);
      REG_COLOR:  prdata = 32'(color_factor);
      default:    prdata = '0;
    endcase
  end

  // Input decode
  logic [1:0]  in_mode, in_seed;
  logic [5:0]  in_slot;
  logic [23:0] in_pix;
  logic        accept, slot_ok;
  assign in_mode = s_tuser;
  assign in_slot = s_tdata[5:0];
  assign in_pix  = {s_tdata[13:6], s_tdata[21:14], s_tdata[29:22]};
  assign in_seed = s_tdata[31:30];
  assign accept  = s_tvalid && s_tready;
  assign slot_ok = {1'b0, in_slot} < 7'(NUM_CENTERS);

  // Centre tables
  logic [23:0] fore_tab [NUM_CENTERS];
  logic [23:0] back_tab [NUM_CENTERS];
  always_ff @(posedge clk) begin
    if (accept && slot_ok && in_mode == MODE_FORE) fore_tab[in_slot[CW-1:0]] <= in_pix;
    if (accept && slot_ok && in_mode == MODE_BACK) back_tab[in_slot[CW-1:0]] <= in_pix;
  end

  // Scan position, normalized against the current size
  logic [XW-1:0] col;
  logic [YW-1:0] row;
  logic [23:0]   left_pixel;
  logic [12:0]   w13, h13, w_eff, h_eff, row_pre, row_eff;
  logic [XW-1:0] col_eff;
  logic          wrap_pre;
  assign w13      = 13'(image_width);
  assign h13      = image_height;
  assign w_eff    = (w13 == 13'd0) ? 13'd1 : ((w13 > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : w13);
  assign h_eff    = (h13 == 13'd0) ? 13'd1 : ((h13 > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : h13);
  assign wrap_pre = 13'(col) >= w_eff;
  assign col_eff  = wrap_pre ? '0 : col;
  assign row_pre  = wrap_pre ? 13'(row) + 13'd1 : 13'(row);
  assign row_eff  = (row_pre >= h_eff) ? 13'd0 : row_pre;

  // Work registers of the pixel in flight
  logic [23:0]   pix_r;
  logic [1:0]    seed_r;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [12:0]   w_r, h_r;
  logic [23:0]   row_rd;
  logic [17:0]   q_left, q_up, minf, minb, qf, qb;
  logic [CW-1:0] idx;
  logic [1:0]    op;
  logic [16:0]   rf, rb, rl, ru;
  logic [17:0]   dsum;
  logic [26:0]   tf, tb, half;
  logic [21:0]   node;
  logic [43:0]   numf, numb;
  logic [23:0]   quo_f, quo_b, quo_l, quo_u;
  logic [8:0]    cf;
  logic [12:0]   col_nx, row_nx;
  logic          last;

  assign qf     = sq_dist(pix_r, fore_tab[idx]);
  assign qb     = sq_dist(pix_r, back_tab[idx]);
  assign cf     = (color_factor > 9'd256) ? 9'd256 : color_factor;
  assign col_nx = 13'(cx) + 13'd1;
  assign row_nx = 13'(cy) + 13'd1;
  assign last   = (col_nx == w_r) && (row_nx == h_r);

  // Line store: read at accept, write the pixel at the end
  logic [23:0] row_store [MAX_WIDTH];
  logic        out_load;
  always_ff @(posedge clk) begin
    if (accept) row_rd <= row_store[col_eff];
    if (out_load) row_store[cx] <= pix_r;
  end

  // Shared sqrt and divider
  logic        sq_start, sq_done, dv_start, dv_done;
  logic [17:0] sq_val;
  logic [16:0] sq_root;
  logic [43:0] dv_num;
  logic [19:0] dv_den;
  logic [23:0] dv_quot;

  always_comb begin
    case (op)
      OP_FORE: sq_val = minf;
      OP_BACK: sq_val = minb;
      OP_LEFT: sq_val = q_left;
      default: sq_val = q_up;
    endcase
  end

  always_comb begin
    case (op)
      OP_FORE: begin dv_num = numf; dv_den = 20'({dsum, 1'b0}); end
      OP_BACK: begin dv_num = numb; dv_den = 20'({dsum, 1'b0}); end
      OP_LEFT: begin dv_num = 44'({scale_factor, 16'b0}); dv_den = 20'(rl) + 20'd256; end
      default: begin dv_num = 44'({scale_factor, 16'b0}); dv_den = 20'(ru) + 20'd256; end
    endcase
  end

  gce_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .value(sq_val), .done(sq_done), .root(sq_root)
  );

  gce_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quot(dv_quot)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (accept && in_mode == MODE_PIXEL) state_next = S_DIST;
      S_DIST:    state_next = S_SCAN;
      S_SCAN:    if (idx == CW'(NUM_CENTERS - 1)) state_next = S_SQ_GO;
      S_SQ_GO:   state_next = S_SQ_WAIT;
      S_SQ_WAIT: if (sq_done) state_next = (op == OP_UP) ? S_MUL1 : S_SQ_GO;
      S_MUL1:    state_next = S_MUL2;
      S_MUL2:    state_next = S_MUL3;
      S_MUL3:    state_next = S_DV_GO;
      S_DV_GO:   state_next = S_DV_WAIT;
      S_DV_WAIT: if (dv_done) state_next = (op == OP_UP) ? S_DONE : S_DV_GO;
      S_DONE:    if (out_load) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready = (state == S_IDLE);
    sq_start = (state == S_SQ_GO);
    dv_start = (state == S_DV_GO);
    out_load = (state == S_DONE) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Datapath steps
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        pix_r  <= in_pix;
        seed_r <= in_seed;
        cx     <= col_eff;
        cy     <= row_eff[YW-1:0];
        w_r    <= w_eff;
        h_r    <= h_eff;
      end
      S_DIST: begin
        q_left <= sq_dist(pix_r, left_pixel);
        q_up   <= sq_dist(pix_r, row_rd);
        idx    <= '0;
      end
      S_SCAN: begin
        if (idx == '0 || qf < minf) minf <= qf;
        if (idx == '0 || qb < minb) minb <= qb;
        idx <= idx + CW'(1);
        op  <= OP_FORE;
      end
      S_SQ_WAIT: if (sq_done) begin
        case (op)
          OP_FORE: rf <= sq_root;
          OP_BACK: rb <= sq_root;
          OP_LEFT: rl <= sq_root;
          default: ru <= sq_root;
        endcase
        op <= op + 2'd1;
      end
      S_MUL1: begin
        dsum <= 18'(rf) + 18'(rb);
        tf   <= 27'({cf, 1'b0}) * 27'(rf);
        tb   <= 27'({cf, 1'b0}) * 27'(rb);
        half <= 27'(9'd256 - cf) * (27'(rf) + 27'(rb));
        node <= 22'(cy) * 22'(w_r);
      end
      S_MUL2: numf <= 44'(scale_factor) * (44'(tf) + 44'(half));
      S_MUL3: begin
        numb <= 44'(scale_factor) * (44'(tb) + 44'(half));
        op   <= OP_FORE;
      end
      S_DV_WAIT: if (dv_done) begin
        case (op)
          OP_FORE: quo_f <= dv_quot;
          OP_BACK: quo_b <= dv_quot;
          OP_LEFT: quo_l <= dv_quot;
          default: quo_u <= dv_quot;
        endcase
        op <= op + 2'd1;
      end
      default: ;
    endcase
  end

  // Result register and scan advance
  logic [23:0] cost_f, cost_b;
  logic        lv, uv;
  assign lv = cx != '0;
  assign uv = cy != '0;
  always_comb begin
    if (seed_r == SEED_FORE) begin
      cost_f = '0;
      cost_b = INF_COST;
    end else if (seed_r == SEED_BACK) begin
      cost_f = INF_COST;
      cost_b = '0;
    end else if (dsum == '0) begin
      cost_f = 24'({scale_factor, 7'b0});
      cost_b = 24'({scale_factor, 7'b0});
    end else begin
      cost_f = quo_f;
      cost_b = quo_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      col        <= '0;
      row        <= '0;
      left_pixel <= '0;
    end else if (out_load) begin
      m_tvalid   <= 1'b1;
      left_pixel <= pix_r;
      if (col_nx >= w_r) begin
        col <= '0;
        row <= (row_nx >= h_r) ? '0 : row_nx[YW-1:0];
      end else begin
        col <= col_nx[XW-1:0];
        row <= cy;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {uv, uv ? quo_u : 24'd0, lv, lv ? quo_l : 24'd0, cost_b, cost_f,
                  22'(node + 22'(cx))};
      m_tlast <= last;
    end
  end

endmodule
